// File: design/ctod_pkg.sv
`timescale 1ns / 1ps

package ctod_pkg;

   // term kinds
   localparam logic [2:0] KIND_LITERAL   = 3'd0;
   localparam logic [2:0] KIND_INTEGER   = 3'd1;
   localparam logic [2:0] KIND_ATOM      = 3'd2;
   localparam logic [2:0] KIND_XREG      = 3'd3;
   localparam logic [2:0] KIND_YREG      = 3'd4;
   localparam logic [2:0] KIND_LABEL     = 3'd5;
   localparam logic [2:0] KIND_CHAR      = 3'd6;
   localparam logic [2:0] KIND_LIT_INDEX = 3'd7;

   // error codes
   localparam logic [3:0] ERR_NONE     = 4'd0;
   localparam logic [3:0] ERR_ATOM     = 4'd1;
   localparam logic [3:0] ERR_LABEL    = 4'd2;
   localparam logic [3:0] ERR_XREG     = 4'd3;
   localparam logic [3:0] ERR_YREG     = 4'd4;
   localparam logic [3:0] ERR_CHAR     = 4'd5;
   localparam logic [3:0] ERR_LITERAL  = 4'd6;
   localparam logic [3:0] ERR_OVERFLOW = 4'd7;
   localparam logic [3:0] ERR_UNSUP    = 4'd8;
   localparam logic [3:0] ERR_BAD_TAG  = 4'd9;

   // tag field values
   localparam logic [2:0] TAG_EXTENDED = 3'd7;
   localparam logic [3:0] EXT_LITERAL  = 4'd5;
   localparam logic [3:0] EXT_UNSUP_LO = 4'd1;
   localparam logic [3:0] EXT_UNSUP_HI = 4'd4;
   localparam logic [2:0] LEN_BIGINT   = 3'd7;

   localparam logic [62:0] CHAR_MAX = 63'd65535;

   // configuration register indexes
   localparam logic [2:0] CSR_ATOM_COUNT    = 3'd0;
   localparam logic [2:0] CSR_LABEL_COUNT   = 3'd1;
   localparam logic [2:0] CSR_LITERAL_COUNT = 3'd2;
   localparam logic [2:0] CSR_X_REG_LIMIT   = 3'd3;
   localparam logic [2:0] CSR_Y_REG_LIMIT   = 3'd4;

   typedef enum logic [2:0] {
      ST_FIRST,
      ST_LITFIRST,
      ST_SHORT,
      ST_MBFIRST,
      ST_MBREST,
      ST_MBOVF
   } phase_type;

   // operand handed from parser to checker
   typedef struct packed {
      logic [2:0]  kind;
      logic [62:0] value;
      logic [3:0]  err;
   } term_type;

   typedef struct packed {
      logic [15:0] atom_count;
      logic [15:0] label_count;
      logic [15:0] literal_count;
      logic [10:0] x_reg_limit;
      logic [10:0] y_reg_limit;
   } cfg_type;

endpackage

// File: design/ctod_front.sv
`timescale 1ns / 1ps

module ctod_front import ctod_pkg::*; #(
   parameter int MAX_INT_BYTES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   output logic       push,
   output term_type   push_word
);

   localparam int ACC_W = 8 * MAX_INT_BYTES;
   localparam logic [3:0] MAX_BYTES = 4'(MAX_INT_BYTES);

   phase_type         state_ff, state_in;
   logic [2:0]        pending_kind_ff, pending_kind_in;
   logic [3:0]        bytes_left_ff, bytes_left_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;

   logic              do_begin;
   logic [2:0]        begin_kind;
   logic [3:0]        count;
   logic [3:0]        left;
   logic              ovf;
   logic [ACC_W-1:0]  acc_shift;
   logic [63:0]       acc_wide;

   assign acc_shift = {acc_ff[ACC_W-9:0], data_byte};
   assign acc_wide  = 64'(acc_shift);
   assign count     = {1'b0, data_byte[7:5]} + 4'd2;
   assign left      = bytes_left_ff - 4'd1;
   assign ovf       = (state_ff == ST_MBOVF) || ((state_ff == ST_MBFIRST) && data_byte[7]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_FIRST;
         pending_kind_ff <= KIND_LITERAL;
         bytes_left_ff   <= 4'd0;
      end else begin
         state_ff        <= state_in;
         pending_kind_ff <= pending_kind_in;
         bytes_left_ff   <= bytes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   always_comb begin
      state_in        = state_ff;
      pending_kind_in = pending_kind_ff;
      bytes_left_in   = bytes_left_ff;
      acc_in          = acc_ff;
      push            = 1'b0;
      push_word.kind  = pending_kind_ff;
      push_word.value = '0;
      push_word.err   = ERR_NONE;
      do_begin        = 1'b0;
      begin_kind      = data_byte[2:0];

      if (accept) begin
         case (state_ff)
            ST_FIRST: begin
               if (data_byte[2:0] != TAG_EXTENDED) begin
                  do_begin = 1'b1;
               end else if (data_byte[7:4] >= EXT_UNSUP_LO && data_byte[7:4] <= EXT_UNSUP_HI) begin
                  push           = 1'b1;
                  push_word.kind = KIND_LITERAL;
                  push_word.err  = ERR_UNSUP;
               end else if (data_byte[7:4] == EXT_LITERAL) begin
                  pending_kind_in = KIND_LIT_INDEX;
                  state_in        = ST_LITFIRST;
               end else begin
                  push           = 1'b1;
                  push_word.kind = KIND_LITERAL;
                  push_word.err  = ERR_BAD_TAG;
               end
            end
            ST_LITFIRST: begin
               begin_kind = KIND_LIT_INDEX;
               if (data_byte[2:0] == TAG_EXTENDED) begin
                  push           = 1'b1;
                  push_word.kind = KIND_LIT_INDEX;
                  push_word.err  = ERR_BAD_TAG;
                  state_in       = ST_FIRST;
               end else begin
                  do_begin = 1'b1;
               end
            end
            ST_SHORT: begin
               push            = 1'b1;
               push_word.value = 63'({acc_ff[10:8], data_byte});
               state_in        = ST_FIRST;
            end
            ST_MBFIRST, ST_MBREST, ST_MBOVF: begin
               if (!ovf) begin
                  acc_in = acc_shift;
               end
               bytes_left_in = left;
               if (left == 4'd0) begin
                  push            = 1'b1;
                  push_word.err   = ovf ? ERR_OVERFLOW : ERR_NONE;
                  push_word.value = ovf ? 63'd0 : acc_wide[62:0];
                  state_in        = ST_FIRST;
               end else begin
                  state_in = ovf ? ST_MBOVF : ST_MBREST;
               end
            end
            default: begin
               state_in = ST_FIRST;
            end
         endcase

         // start of a value: inline, short or multi-byte form, or an unsupported big-integer length
         if (do_begin) begin
            pending_kind_in = begin_kind;
            push_word.kind  = begin_kind;
            state_in        = ST_FIRST;
            if (!data_byte[3]) begin
               push            = 1'b1;
               push_word.value = 63'(data_byte[7:4]);
            end else if (!data_byte[4]) begin
               acc_in   = ACC_W'({data_byte[7:5], 8'h00});
               state_in = ST_SHORT;
            end else if (data_byte[7:5] == LEN_BIGINT) begin
               push          = 1'b1;
               push_word.err = ERR_UNSUP;
            end else begin
               bytes_left_in = count;
               acc_in        = '0;
               state_in      = (count > MAX_BYTES) ? ST_MBOVF : ST_MBFIRST;
            end
         end
      end
   end

   a_mb_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MBFIRST || state_ff == ST_MBREST || state_ff == ST_MBOVF)
         |-> bytes_left_ff != 4'd0)
      else $error("multi-byte state with no bytes left");

   a_push_resync: assert property (@(posedge clock) disable iff (reset)
      push |=> state_ff == ST_FIRST)
      else $error("parser not back at first byte after a word");

   a_lit_kind: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LITFIRST |-> pending_kind_ff == KIND_LIT_INDEX)
      else $error("literal tag without literal kind");

endmodule

// File: design/ctod_queue.sv
`timescale 1ns / 1ps

module ctod_queue import ctod_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  term_type push_word,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output term_type pop_word
);

   term_type   mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_word = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != 2'd2)
      else $error("push into full queue");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule

// File: design/ctod_back.sv
`timescale 1ns / 1ps

module ctod_back import ctod_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        empty,
   input  term_type    word,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [62:0] rsp_value,
   output logic        rsp_null,
   output logic [3:0]  rsp_err
);

   logic        valid_ff, valid_in;
   logic [2:0]  kind_ff;
   logic [62:0] value_ff, value_in;
   logic        null_ff, null_in;
   logic [3:0]  err_ff, err_in;
   logic        load;
   logic        is_zero;

   assign load    = !valid_ff || rsp_ready;
   assign pop     = load && !empty;
   assign is_zero = (word.value == 63'd0);

   always_comb begin
      err_in  = word.err;
      null_in = 1'b0;
      if (word.err == ERR_NONE) begin
         case (word.kind)
            KIND_ATOM: begin
               if (is_zero) null_in = 1'b1;
               else if (word.value > 63'(cfg.atom_count)) err_in = ERR_ATOM;
            end
            KIND_XREG: begin
               if (word.value >= 63'(cfg.x_reg_limit)) err_in = ERR_XREG;
            end
            KIND_YREG: begin
               if (word.value >= 63'(cfg.y_reg_limit)) err_in = ERR_YREG;
            end
            KIND_LABEL: begin
               if (is_zero) null_in = 1'b1;
               else if (word.value >= 63'(cfg.label_count)) err_in = ERR_LABEL;
            end
            KIND_CHAR: begin
               if (word.value > CHAR_MAX) err_in = ERR_CHAR;
            end
            KIND_LIT_INDEX: begin
               if (word.value >= 63'(cfg.literal_count)) err_in = ERR_LITERAL;
            end
            default: begin
            end
         endcase
      end
      value_in = (err_in == ERR_NONE) ? word.value : 63'd0;
      if (err_in != ERR_NONE) null_in = 1'b0;
      valid_in = load ? !empty : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= word.kind;
         value_ff <= value_in;
         null_ff  <= null_in;
         err_ff   <= err_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_value = value_ff;
   assign rsp_null  = null_ff;
   assign rsp_err   = err_ff;

   a_err_clears: assert property (@(posedge clock) disable iff (reset)
      valid_ff && err_ff != ERR_NONE |-> value_ff == 63'd0 && !null_ff)
      else $error("error word carries value or null");

   a_null_kind: assert property (@(posedge clock) disable iff (reset)
      valid_ff && null_ff |-> (kind_ff == KIND_ATOM || kind_ff == KIND_LABEL)
         && value_ff == 63'd0)
      else $error("null flag on wrong kind");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_CHAR && err_ff == ERR_NONE |-> value_ff <= CHAR_MAX)
      else $error("character out of range passed");

endmodule

// File: design/compact_term_operand_decoder_unit.sv
`timescale 1ns / 1ps

// Compact term operand decoder. Takes one stream byte per clock on req_ and
// returns one word on rsp_ for each completed operand (1, 2 or 3 to 9 bytes,
// one more behind an extended literal tag; bad or unsupported tags end after
// one or two bytes). Sustained rate is one byte per cycle while req_tready is
// high. The byte parser feeds a two-word queue, and the range checker drains
// it into the output register; req_tready drops only when that queue holds
// two words, which happens when rsp_tready stays low. After any error the
// next byte is decoded as the first byte of a new operand. Limits on csr_
// are to be written by the user only while the block is idle; the block
// itself does not enforce this. csr_ready is always high.

module compact_term_operand_decoder_unit import ctod_pkg::*; #(
   parameter int MAX_INT_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // [62:0] term_value, [63] is_null,
                                     // [67:64] error_code, [71:68] zero
   output logic [2:0]  rsp_tuser,    // [2:0] term_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type     cfg_ff;
   logic        accept;
   logic        push, pop, full, empty;
   term_type    push_word, pop_word;
   logic [2:0]  kind;
   logic [62:0] value;
   logic        nul;
   logic [3:0]  err;

   assign csr_ready  = 1'b1;
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.atom_count    <= 16'd0;
         cfg_ff.label_count   <= 16'd0;
         cfg_ff.literal_count <= 16'd0;
         cfg_ff.x_reg_limit   <= 11'd1024;
         cfg_ff.y_reg_limit   <= 11'd1024;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ATOM_COUNT:    cfg_ff.atom_count    <= csr_data;
            CSR_LABEL_COUNT:   cfg_ff.label_count   <= csr_data;
            CSR_LITERAL_COUNT: cfg_ff.literal_count <= csr_data;
            CSR_X_REG_LIMIT:   cfg_ff.x_reg_limit   <= csr_data[10:0];
            CSR_Y_REG_LIMIT:   cfg_ff.y_reg_limit   <= csr_data[10:0];
            default: begin
            end
         endcase
      end
   end

   ctod_front #(
      .MAX_INT_BYTES (MAX_INT_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .push      (push),
      .push_word (push_word)
   );

   ctod_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .pop_word  (pop_word)
   );

   ctod_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .empty     (empty),
      .word      (pop_word),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (kind),
      .rsp_value (value),
      .rsp_null  (nul),
      .rsp_err   (err)
   );

   assign rsp_tdata = {4'd0, err, nul, value};
   assign rsp_tuser = kind;

endmodule
